// ===== design/dtt_pkg.sv =====
// Shared types and constants for the deferred-trust tracker.
package dtt_pkg;

  localparam int DEF_MAX_HOLDERS    = 8;
  localparam int DEF_MODULE_ID_BITS = 8;

  localparam int MODULE_ID_W = 8;
  localparam int COUNT_W     = 4;

  typedef enum logic [1:0] {
    MODE_OFF       = 2'd0,
    MODE_ON        = 2'd1,
    MODE_DEFERRING = 2'd2,
    MODE_DO_TRUST  = 2'd3
  } mode_t;

  typedef enum logic {
    KIND_DEFER    = 1'b0,
    KIND_FINALIZE = 1'b1
  } kind_t;

  typedef struct packed {
    logic                   kind;
    logic [MODULE_ID_W-1:0] mod_id;
    logic                   defer_on;
    logic                   was_blocked;
    logic                   was_allowed;
    logic                   was_trusted;
  } in_beat_t;

  typedef struct packed {
    logic               request_trust;
    logic               request_allow;
    logic [1:0]         mode;
    logic [COUNT_W-1:0] holder_count;
    logic               set_full;
  } out_beat_t;

  // Per-beat commands broadcast to every holder cell.
  typedef struct packed {
    logic insert;
    logic remove;
    logic flush;
  } cell_ctrl_t;

endpackage

// ===== design/dtt_cell.sv =====
// One holder cell: a valid bit and a module id, with a lowest-free-slot ripple.
module dtt_cell import dtt_pkg::*; #(
  parameter int MODULE_ID_BITS = DEF_MODULE_ID_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cell_ctrl_t                ctrl,
  input  logic [MODULE_ID_BITS-1:0] id_in,
  input  logic                      taken_in,
  output logic                      taken_out,
  output logic                      match
);

  logic                      valid_r, valid_nxt;
  logic [MODULE_ID_BITS-1:0] id_r, id_nxt;
  logic                      claim;

  assign match     = valid_r && (id_r == id_in);
  // A free cell takes the insert only if no cell to its left is free.
  assign claim     = ctrl.insert && !valid_r && !taken_in;
  assign taken_out = taken_in || !valid_r;

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    priority if (ctrl.flush) begin
      valid_nxt = 1'b0;
    end else if (claim) begin
      valid_nxt = 1'b1;
      id_nxt    = id_in;
    end else if (ctrl.remove && match) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

endmodule

// ===== design/deferred_trust_tracker.sv =====
// Top level of the deferred-trust tracker: beat register, mode logic, holder cell row.
//
//   channel | ports                    | handshake
//   --------+--------------------------+----------------------------------
//   input   | start, busy, in_beat     | beat taken when start && !busy
//   result  | out_valid, out_beat      | one-cycle strobe, never stalled
//
// The accept edge latches a beat (busy goes high); the
// next edge updates the cell row and mode and registers the result, so
// out_valid pulses the cycle after busy. A new beat is not taken while busy is
// high, so each beat is finished before the next one is accepted.
// Reset (rst_n low, synchronous) empties the set, sets mode off, drops busy.
// The receiver cannot stall; nothing here waits on it.
module deferred_trust_tracker import dtt_pkg::*; #(
  parameter int MAX_HOLDERS    = DEF_MAX_HOLDERS,
  parameter int MODULE_ID_BITS = DEF_MODULE_ID_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  output out_beat_t out_beat
);

  localparam int CntW    = $clog2(MAX_HOLDERS + 1);
  localparam int CntExtW = (CntW > COUNT_W) ? CntW : COUNT_W;
  localparam int IdExtW  = (MODULE_ID_BITS > MODULE_ID_W) ? MODULE_ID_BITS : MODULE_ID_W;

  // Latched beat, processed in the cycle after accept.
  logic      pend_r;
  in_beat_t  beat_r;

  mode_t           mode_r, mode_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  logic      out_valid_r;
  out_beat_t out_beat_r, out_beat_nxt;

  logic [IdExtW-1:0]         id_ext;
  logic [MODULE_ID_BITS-1:0] id_w;
  logic [MAX_HOLDERS:0]      taken;
  logic [MAX_HOLDERS-1:0]    match;
  logic                      found;
  logic                      is_defer;
  logic                      set_full;
  cell_ctrl_t                ctrl;
  logic [CntExtW-1:0]        cnt_ext;

  assign busy      = pend_r;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // Ids are kept on their low MODULE_ID_BITS bits.
  assign id_ext = IdExtW'(beat_r.mod_id);
  assign id_w   = id_ext[MODULE_ID_BITS-1:0];

  assign taken[0] = 1'b0;

  for (genvar g = 0; g < MAX_HOLDERS; g++) begin : g_cell
    dtt_cell #(
      .MODULE_ID_BITS(MODULE_ID_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .id_in    (id_w),
      .taken_in (taken[g]),
      .taken_out(taken[g+1]),
      .match    (match[g])
    );
  end

  assign found    = |match;
  assign is_defer = (beat_r.kind == KIND_DEFER);

  // taken[MAX_HOLDERS] low means no free cell anywhere in the row.
  assign set_full = pend_r && is_defer && beat_r.defer_on && !found && !taken[MAX_HOLDERS];

  always_comb begin
    ctrl.insert = pend_r && is_defer && beat_r.defer_on && !found;
    ctrl.remove = pend_r && is_defer && !beat_r.defer_on;
    ctrl.flush  = pend_r && !is_defer &&
                  (beat_r.was_blocked || (mode_r == MODE_DO_TRUST && beat_r.was_allowed));
  end

  always_comb begin
    mode_nxt     = mode_r;
    cnt_nxt      = cnt_r;
    out_beat_nxt = '0;
    if (pend_r) begin
      if (is_defer) begin
        if (beat_r.defer_on) begin
          // First holder: mode moves before the insert.
          if (cnt_r == '0) begin
            mode_nxt = (mode_r == MODE_DO_TRUST) ? MODE_DEFERRING : MODE_ON;
          end
          if (!found && !set_full) begin
            cnt_nxt = cnt_r + CntW'(1);
          end
        end else if (found) begin
          cnt_nxt = cnt_r - CntW'(1);
          // Last holder gone.
          if (cnt_r == CntW'(1)) begin
            mode_nxt = (mode_r == MODE_DEFERRING) ? MODE_DO_TRUST : MODE_OFF;
          end
        end
      end else begin
        priority if (beat_r.was_blocked) begin
          mode_nxt = MODE_OFF;
          cnt_nxt  = '0;
        end else if (mode_r == MODE_DO_TRUST && beat_r.was_allowed) begin
          out_beat_nxt.request_trust = 1'b1;
          mode_nxt = MODE_OFF;
          cnt_nxt  = '0;
        end else if ((mode_r == MODE_ON || mode_r == MODE_DEFERRING) && beat_r.was_trusted) begin
          out_beat_nxt.request_allow = 1'b1;
          mode_nxt = MODE_DEFERRING;
        end else begin
          mode_nxt = mode_r;
        end
      end
    end
    cnt_ext                   = CntExtW'(cnt_nxt);
    out_beat_nxt.mode         = mode_nxt;
    out_beat_nxt.holder_count = cnt_ext[COUNT_W-1:0];
    out_beat_nxt.set_full     = set_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      mode_r      <= MODE_OFF;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= start && !pend_r;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !pend_r) begin
      beat_r <= in_beat;
    end
    out_beat_r <= out_beat_nxt;
  end

endmodule

// ===== design/dtt_checker.sv =====
// Port-level checks for the deferred-trust tracker, bound to the top level.
module dtt_checker import dtt_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_beat_t out_beat
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy)
    else $error("result strobe did not follow busy");

  a_trust_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.request_trust |->
      out_beat.mode == MODE_OFF && out_beat.holder_count == '0)
    else $error("trust request left tracker populated");

  a_allow_defers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.request_allow |-> out_beat.mode == MODE_DEFERRING)
    else $error("allow request without deferring mode");

  a_holders_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.holder_count != '0 |->
      out_beat.mode == MODE_ON || out_beat.mode == MODE_DEFERRING)
    else $error("holders present in off or do-trust mode");

endmodule

bind deferred_trust_tracker dtt_checker u_dtt_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_beat (out_beat)
);

// ===== test/deferred_trust_tracker_test.sv =====
// Self-checking testbench for the deferred-trust tracker: directed table, then random beats.
module deferred_trust_tracker_test;
  import dtt_pkg::*;

  localparam int HOLDERS      = DEF_MAX_HOLDERS;
  localparam int RANDOM_BEATS = 1950;
  // Cycles without any accepted beat on either side before we give up.
  localparam int STALL_LIMIT  = 2000;

  // One row of the directed table: the beat, plus a hand-written result
  // where it is obvious; otherwise the tracker model supplies it.
  typedef struct {
    in_beat_t  beat;
    bit        given;
    out_beat_t want;
  } plan_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_beat;
  logic      out_valid;
  out_beat_t out_beat;

  // Tracker model state: mode plus the holder set.
  mode_t                  trk_mode;
  logic [MODULE_ID_W-1:0] held_id  [HOLDERS];
  bit                     held_vld [HOLDERS];

  out_beat_t pending [$];   // expected results, oldest first
  int        errors;
  int        results_seen;
  int        quiet_cycles;
  bit        steady_run;    // suppresses sender idling

  deferred_trust_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH result %0d: %s", results_seen, msg);
    errors++;
  endtask

  function automatic int held_count();
    int n;
    n = 0;
    for (int i = 0; i < HOLDERS; i++) if (held_vld[i]) n++;
    return n;
  endfunction

  function automatic void clear_holders();
    trk_mode = MODE_OFF;
    for (int i = 0; i < HOLDERS; i++) held_vld[i] = 1'b0;
  endfunction

  // Advance the tracker model by one beat and return the result it owes.
  function automatic out_beat_t track_beat(input in_beat_t b);
    out_beat_t r;
    bit        found;
    int        free_slot;
    r         = '0;
    found     = 1'b0;
    free_slot = -1;
    if (b.kind == KIND_DEFER) begin
      if (b.defer_on) begin
        // Set going non-empty: do-trust falls back to deferring, else on.
        if (held_count() == 0) begin
          trk_mode = (trk_mode == MODE_DO_TRUST) ? MODE_DEFERRING : MODE_ON;
        end
        for (int i = 0; i < HOLDERS; i++) begin
          if (held_vld[i]) begin
            if (held_id[i] == b.mod_id) found = 1'b1;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (!found) begin
          if (free_slot >= 0) begin
            held_id[free_slot]  = b.mod_id;
            held_vld[free_slot] = 1'b1;
          end else begin
            r.set_full = 1'b1;
          end
        end
      end else if (held_count() != 0) begin
        for (int i = 0; i < HOLDERS; i++) begin
          if (held_vld[i] && held_id[i] == b.mod_id) held_vld[i] = 1'b0;
        end
        // Last holder gone: deferring earns trust, anything else shuts off.
        if (held_count() == 0) begin
          trk_mode = (trk_mode == MODE_DEFERRING) ? MODE_DO_TRUST : MODE_OFF;
        end
      end
    end else begin
      if (b.was_blocked) begin
        clear_holders();
      end else if (trk_mode == MODE_DO_TRUST && b.was_allowed) begin
        r.request_trust = 1'b1;
        clear_holders();
      end else if ((trk_mode == MODE_ON || trk_mode == MODE_DEFERRING) && b.was_trusted) begin
        trk_mode        = MODE_DEFERRING;
        r.request_allow = 1'b1;
      end
    end
    r.mode         = trk_mode;
    r.holder_count = COUNT_W'(held_count());
    return r;
  endfunction

  function automatic plan_row_t plan_row(input logic k, input logic [7:0] id, input logic on,
                                         input logic blk, input logic alw, input logic tru,
                                         input bit given, input out_beat_t want);
    plan_row_t r;
    r.beat  = '{kind: k, mod_id: id, defer_on: on,
                was_blocked: blk, was_allowed: alw, was_trusted: tru};
    r.given = given;
    r.want  = want;
    return r;
  endfunction

  // Present one beat, maybe after a random idle gap, and hold it until taken.
  // busy is sampled at the falling edge so the accept decision is race free.
  task automatic send_beat(input in_beat_t b, input bit given, input out_beat_t want);
    out_beat_t pred;
    if (!steady_run && $urandom_range(99) < 21) begin
      start          <= 1'b0;
      in_beat.mod_id <= 8'($urandom);
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    in_beat <= b;
    do @(negedge clk); while (busy);
    @(posedge clk);
    pred = track_beat(b);
    pending.push_back(given ? want : pred);
  endtask

  // Result checker: the strobe lasts one cycle, so sample it mid-cycle.
  always @(negedge clk) begin : check_results
    out_beat_t want;
    if (rst_n && out_valid) begin
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_beat));
      end else begin
        want = pending.pop_front();
        if (out_beat.request_trust !== want.request_trust)
          report_mismatch($sformatf("request_trust got %b want %b",
                                    out_beat.request_trust, want.request_trust));
        if (out_beat.request_allow !== want.request_allow)
          report_mismatch($sformatf("request_allow got %b want %b",
                                    out_beat.request_allow, want.request_allow));
        if (out_beat.mode !== want.mode)
          report_mismatch($sformatf("mode got %0d want %0d", out_beat.mode, want.mode));
        if (out_beat.holder_count !== want.holder_count)
          report_mismatch($sformatf("holder_count got %0d want %0d",
                                    out_beat.holder_count, want.holder_count));
        if (out_beat.set_full !== want.set_full)
          report_mismatch($sformatf("set_full got %b want %b",
                                    out_beat.set_full, want.set_full));
      end
      results_seen++;
    end
  end

  // Watchdog: any accepted beat on either side counts as progress.
  always @(negedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin : stimulus
    plan_row_t              plan [$];
    in_beat_t               b;
    logic [MODULE_ID_W-1:0] id_pool [12];

    rst_n        = 1'b0;
    start        = 1'b0;
    in_beat      = '0;
    errors       = 0;
    results_seen = 0;
    quiet_cycles = 0;
    steady_run   = 1'b0;
    clear_holders();
    for (int i = 0; i < HOLDERS; i++) held_id[i] = '0;

    // Directed walk: empty-set corners, duplicate insert, fill to full and
    // overflow, every finalize rule, and the do-trust round trip.
    plan.push_back(plan_row(KIND_FINALIZE, 8'hA5, 1, 0, 1, 1, 1, '{0, 0, MODE_OFF, 0, 0}));
    plan.push_back(plan_row(KIND_DEFER,    8'h00, 0, 0, 0, 0, 1, '{0, 0, MODE_OFF, 0, 0}));
    plan.push_back(plan_row(KIND_DEFER,    8'h00, 1, 0, 0, 0, 1, '{0, 0, MODE_ON, 1, 0}));
    // same id again, verdict bits set but ignored on a defer beat
    plan.push_back(plan_row(KIND_DEFER,    8'h00, 1, 1, 1, 1, 1, '{0, 0, MODE_ON, 1, 0}));
    plan.push_back(plan_row(KIND_DEFER,    8'hFF, 1, 0, 0, 0, 1, '{0, 0, MODE_ON, 2, 0}));
    plan.push_back(plan_row(KIND_DEFER,    8'h01, 1, 0, 0, 0, 0, '0));
    plan.push_back(plan_row(KIND_DEFER,    8'h02, 1, 0, 0, 0, 0, '0));
    plan.push_back(plan_row(KIND_DEFER,    8'h03, 1, 0, 0, 0, 0, '0));
    plan.push_back(plan_row(KIND_DEFER,    8'h04, 1, 0, 0, 0, 0, '0));
    plan.push_back(plan_row(KIND_DEFER,    8'h05, 1, 0, 0, 0, 0, '0));
    plan.push_back(plan_row(KIND_DEFER,    8'h06, 1, 0, 0, 0, 0, '0));
    // set is full: insert dropped
    plan.push_back(plan_row(KIND_DEFER,    8'hC8, 1, 0, 0, 0, 1, '{0, 0, MODE_ON, 8, 1}));
    plan.push_back(plan_row(KIND_DEFER,    8'h4D, 0, 0, 0, 0, 0, '0));
    plan.push_back(plan_row(KIND_FINALIZE, 8'h5A, 0, 0, 1, 0, 0, '0));
    plan.push_back(plan_row(KIND_FINALIZE, 8'hA5, 1, 0, 0, 1, 1,
                            '{0, 1, MODE_DEFERRING, 8, 0}));
    plan.push_back(plan_row(KIND_FINALIZE, 8'hA5, 1, 1, 1, 1, 1, '{0, 0, MODE_OFF, 0, 0}));
    plan.push_back(plan_row(KIND_DEFER,    8'h05, 1, 0, 0, 0, 1, '{0, 0, MODE_ON, 1, 0}));
    plan.push_back(plan_row(KIND_FINALIZE, 8'h5A, 0, 0, 0, 1, 1,
                            '{0, 1, MODE_DEFERRING, 1, 0}));
    plan.push_back(plan_row(KIND_DEFER,    8'h05, 0, 0, 0, 0, 1, '{0, 0, MODE_DO_TRUST, 0, 0}));
    plan.push_back(plan_row(KIND_DEFER,    8'h03, 1, 0, 0, 0, 1,
                            '{0, 0, MODE_DEFERRING, 1, 0}));
    plan.push_back(plan_row(KIND_DEFER,    8'h03, 0, 0, 0, 0, 1, '{0, 0, MODE_DO_TRUST, 0, 0}));
    // do-trust ignores trusted without allowed
    plan.push_back(plan_row(KIND_FINALIZE, 8'hA5, 1, 0, 0, 1, 0, '0));
    plan.push_back(plan_row(KIND_FINALIZE, 8'h5A, 0, 0, 1, 0, 1, '{1, 0, MODE_OFF, 0, 0}));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_beat(plan[i].beat, plan[i].given, plan[i].want);

    // Random part: most ids come from a small pool so removals hit members
    // and the set fills; blocked verdicts are rare so the set can build up.
    foreach (id_pool[i]) id_pool[i] = 8'($urandom);
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      steady_run = (n >= 700 && n < 1100);
      if (n == 1100 || n == 1500) begin
        // drain the pipe completely before carrying on
        start <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
      end
      b.kind        = ($urandom_range(99) < 22) ? KIND_FINALIZE : KIND_DEFER;
      b.mod_id      = ($urandom_range(99) < 85) ? id_pool[$urandom_range(11)] : 8'($urandom);
      b.defer_on    = ($urandom_range(99) < 55);
      b.was_blocked = ($urandom_range(99) < 12);
      b.was_allowed = 1'($urandom_range(1));
      b.was_trusted = 1'($urandom_range(1));
      send_beat(b, 1'b0, '0);
    end

    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
